// ===== rtl/bell_peak_picker_macros.svh =====
// Assertion helpers used by the picker's core. Every assertion is sampled on
// the rising clock edge and is switched off while reset is asserted.
`ifndef BELL_PEAK_PICKER_MACROS_SVH
`define BELL_PEAK_PICKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bpp_pkg.sv =====
package bpp_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int KEY_CAP_DEF      = 16;
    localparam int INDEX_W          = 16;
    localparam int CFG_W            = 16;

    localparam logic [CFG_W-1:0] MAX_SAMPLES_RST = 16'hFFFF;

    // Picker state, one-hot.
    typedef enum logic [2:0] {
        MODE_SEARCH = 3'b001,
        MODE_LOBE   = 3'b010,
        MODE_END    = 3'b100
    } mode_t;

    // Handshake status handed from the result stage back to the pipeline.
    typedef struct packed {
        logic advance;   // result stage can take a new word this cycle
    } out_stat_t;

endpackage

// ===== rtl/bpp_in_stage.sv =====
module bpp_in_stage #(
    parameter int SAMPLE_WIDTH = bpp_pkg::SAMPLE_WIDTH_DEF,
    parameter int IN_W         = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [IN_W-1:0]                s_tdata,
    input  bpp_pkg::out_stat_t             out_stat,
    output logic                           fire,
    output logic signed [SAMPLE_WIDTH-1:0] sample
);

    logic                           in_valid_reg;
    logic                           in_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;

    // The held word is consumed whenever the result stage has room.
    assign fire     = in_valid_reg && out_stat.advance;
    assign s_tready = !in_valid_reg || out_stat.advance;
    assign sample   = sample_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            sample_reg <= $signed(s_tdata[SAMPLE_WIDTH-1:0]);
        end
    end

endmodule

// ===== rtl/bpp_core.sv =====
`include "bell_peak_picker_macros.svh"

module bpp_core #(
    parameter int SAMPLE_WIDTH = bpp_pkg::SAMPLE_WIDTH_DEF,
    parameter int KEY_CAP      = bpp_pkg::KEY_CAP_DEF,
    parameter int CNT_W        = $clog2(KEY_CAP),
    parameter int RAW_W        = 2 * SAMPLE_WIDTH + 2 * bpp_pkg::INDEX_W + 2 + CNT_W,
    parameter int OUT_W        = ((RAW_W + 7) / 8) * 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fire,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           cfg_we,
    input  logic [bpp_pkg::CFG_W-1:0]      cfg_data,
    output logic                           res_user,
    output logic [OUT_W-1:0]               res_data
);

    localparam int IW = bpp_pkg::INDEX_W;
    localparam logic [CNT_W-1:0] CAP_LAST = CNT_W'(KEY_CAP - 1);

    bpp_pkg::mode_t                 mode_reg, mode_next;
    logic signed [SAMPLE_WIDTH-1:0] prev_reg;
    logic [IW-1:0]                  count_reg, count_next;
    logic signed [SAMPLE_WIDTH-1:0] lobe_val_reg, lobe_val_next;
    logic [IW-1:0]                  lobe_idx_reg, lobe_idx_next;
    logic signed [SAMPLE_WIDTH-1:0] best_val_reg, best_val_next;
    logic [IW-1:0]                  best_idx_reg, best_idx_next;
    logic [CNT_W-1:0]               rec_reg, rec_next;
    logic [bpp_pkg::CFG_W-1:0]      max_samples_reg;

    logic                           valid_n;
    logic                           newg_n;
    logic signed [SAMPLE_WIDTH-1:0] pval_n;
    logic [IW-1:0]                  pidx_n;
    logic                           at_limit;

    // Run limit: max_samples <= count + 1, evaluated one bit wider.
    assign at_limit   = {1'b0, max_samples_reg} <= ({1'b0, count_reg} + (IW + 1)'(1));
    assign count_next = count_reg + IW'(1);

    always_comb
    begin
        mode_next     = mode_reg;
        lobe_val_next = lobe_val_reg;
        lobe_idx_next = lobe_idx_reg;
        best_val_next = best_val_reg;
        best_idx_next = best_idx_reg;
        rec_next      = rec_reg;
        valid_n       = 1'b0;
        newg_n        = 1'b0;
        pval_n        = '0;
        pidx_n        = '0;
        unique case (mode_reg)
            bpp_pkg::MODE_SEARCH:
            begin
                if (prev_reg[SAMPLE_WIDTH-1] && !sample[SAMPLE_WIDTH-1])
                begin
                    lobe_val_next = sample;
                    lobe_idx_next = count_reg;
                    mode_next     = bpp_pkg::MODE_LOBE;
                end
                else if (at_limit)
                begin
                    mode_next = bpp_pkg::MODE_END;
                end
            end
            bpp_pkg::MODE_LOBE:
            begin
                if (!prev_reg[SAMPLE_WIDTH-1] && sample[SAMPLE_WIDTH-1])
                begin
                    if (rec_reg < CAP_LAST)
                    begin
                        rec_next = rec_reg + CNT_W'(1);
                        valid_n  = 1'b1;
                        pval_n   = lobe_val_reg;
                        pidx_n   = lobe_idx_reg;
                        if (best_val_reg < lobe_val_reg)
                        begin
                            best_val_next = lobe_val_reg;
                            best_idx_next = lobe_idx_reg;
                            newg_n        = 1'b1;
                        end
                    end
                    mode_next = bpp_pkg::MODE_SEARCH;
                end
                else if (lobe_val_reg < sample)
                begin
                    lobe_val_next = sample;
                    lobe_idx_next = count_reg;
                end
            end
            bpp_pkg::MODE_END:
            begin
                mode_next = bpp_pkg::MODE_END;
            end
            default:
            begin
                mode_next = bpp_pkg::MODE_SEARCH;
            end
        endcase
    end

    assign res_user = valid_n;
    assign res_data = OUT_W'({(mode_next == bpp_pkg::MODE_END), rec_next,
                              best_idx_next, best_val_next, newg_n, pidx_n, pval_n});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= bpp_pkg::MODE_SEARCH;
            prev_reg     <= '0;
            count_reg    <= '0;
            lobe_val_reg <= '0;
            lobe_idx_reg <= '0;
            best_val_reg <= '0;
            best_idx_reg <= '0;
            rec_reg      <= '0;
        end
        else if (fire)
        begin
            mode_reg     <= mode_next;
            prev_reg     <= sample;
            count_reg    <= count_next;
            lobe_val_reg <= lobe_val_next;
            lobe_idx_reg <= lobe_idx_next;
            best_val_reg <= best_val_next;
            best_idx_reg <= best_idx_next;
            rec_reg      <= rec_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_samples_reg <= bpp_pkg::MAX_SAMPLES_RST;
        end
        else if (cfg_we)
        begin
            max_samples_reg <= cfg_data;
        end
    end

    `BPP_ASSERT_NOW(a_newg_needs_peak, newg_n, valid_n, "new global without a recorded peak")
    `BPP_ASSERT_NEXT(a_end_sticky, mode_reg == bpp_pkg::MODE_END, mode_reg == bpp_pkg::MODE_END, "left the ended state")
    `BPP_ASSERT_NOW(a_cap_bound, 1'b1, rec_reg <= CAP_LAST, "key maximum count beyond capacity")
    `BPP_ASSERT_NEXT(a_rec_step, fire && valid_n, rec_reg == $past(rec_reg) + CNT_W'(1), "recorded count did not advance")

endmodule

// ===== rtl/bpp_out_stage.sv =====
module bpp_out_stage #(
    parameter int OUT_W = 72
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic               res_user,
    input  logic [OUT_W-1:0]   res_data,
    output bpp_pkg::out_stat_t out_stat,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata,
    output logic               m_tuser
);

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [OUT_W-1:0] data_reg;
    logic             user_reg;

    assign out_stat.advance = !out_valid_reg || m_tready;
    assign m_tvalid         = out_valid_reg;
    assign m_tdata          = data_reg;
    assign m_tuser          = user_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_reg <= res_data;
            user_reg <= res_user;
        end
    end

endmodule

// ===== rtl/bell_peak_picker.sv =====
// Key-maximum peak picker. Each input word carries one signed sample; each
// accepted sample yields exactly one output word, in order. A rise from a
// negative to a non-negative sample opens a lobe, the largest sample of the
// lobe and its index are tracked, and a fall to a negative sample closes it.
// A closed lobe is reported as a key maximum (m_tuser high) while fewer than
// KEY_CAP-1 have been reported, and the running global maximum follows any
// strictly larger key maximum. While searching, the run ends once the sample
// count reaches max_samples; after that only a reset restarts the picker.
// Sample indices are 16 bits and wrap. The block takes one word per clock
// while the result stream is not stalled: the whole per-sample update is
// compare-and-select logic between the input register and the result
// register, which drives m_tvalid once the result stage has room; a stalled
// output backs up into s_tready in the same cycle. max_samples (reset 65535)
// is written through the cfg port, which is always ready, and should only
// change while no word is in flight.
module bell_peak_picker #(
    parameter int SAMPLE_WIDTH = bpp_pkg::SAMPLE_WIDTH_DEF,
    parameter int KEY_CAP      = bpp_pkg::KEY_CAP_DEF,
    parameter int CNT_W        = $clog2(KEY_CAP),
    parameter int IN_W         = ((SAMPLE_WIDTH + 7) / 8) * 8,
    parameter int RAW_W        = 2 * SAMPLE_WIDTH + 2 * bpp_pkg::INDEX_W + 2 + CNT_W,
    parameter int OUT_W        = ((RAW_W + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Sample stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [IN_W-1:0]               s_tdata,   // sample
    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [OUT_W-1:0]              m_tdata,   // peak_value, peak_index, new_global,
                                                     // global_value, global_index,
                                                     // peaks_stored, finished
    output logic                          m_tuser,   // peak_valid
    // Configuration: max_samples.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bpp_pkg::CFG_W-1:0]     cfg_data
);

    bpp_pkg::out_stat_t             out_stat;
    logic                           fire;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           res_user;
    logic [OUT_W-1:0]               res_data;

    // Register writes never stall.
    assign cfg_ready = 1'b1;

    bpp_in_stage #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .IN_W         (IN_W)
    ) u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .out_stat (out_stat),
        .fire     (fire),
        .sample   (sample)
    );

    bpp_core #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .KEY_CAP      (KEY_CAP),
        .CNT_W        (CNT_W),
        .RAW_W        (RAW_W),
        .OUT_W        (OUT_W)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .sample   (sample),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .res_user (res_user),
        .res_data (res_data)
    );

    bpp_out_stage #(
        .OUT_W (OUT_W)
    ) u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .res_user (res_user),
        .res_data (res_data),
        .out_stat (out_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
